// ===== design/dad_pkg.sv =====
package dad_pkg;

	localparam int AccW  = 17;
	localparam int YearW = 15;
	localparam int RemW  = 14;

	localparam logic [AccW-1:0]  QuadCentury = AccW'(400);
	localparam logic [RemW-1:0]  RemLast     = RemW'(399);
	localparam logic [2:0]       ModTopShift = 3'd5;
	localparam logic [3:0]       LastMonth   = 4'd11;
	localparam logic [13:0]      YearMax     = 14'd16383;

	typedef logic [AccW-1:0] acc_t;

	typedef struct packed {
		acc_t diff;
		logic ge;
		logic gt;
	} alu_res_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} date_res_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MOD  = 7'b0000010,
		ST_DOY  = 7'b0000100,
		ST_SUM  = 7'b0001000,
		ST_YEAR = 7'b0010000,
		ST_MDAY = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	// Leap test from the year modulo 400; the low two bits also give the year modulo 4.
	function automatic logic is_leap(input logic [RemW-1:0] r);
		is_leap = (r[1:0] == 2'd0) && (r != RemW'(100)) && (r != RemW'(200))
			&& (r != RemW'(300));
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] idx, input logic leap);
		case (idx)
			4'd0:    month_days = 5'd31;
			4'd1:    month_days = leap ? 5'd29 : 5'd28;
			4'd2:    month_days = 5'd31;
			4'd3:    month_days = 5'd30;
			4'd4:    month_days = 5'd31;
			4'd5:    month_days = 5'd30;
			4'd6:    month_days = 5'd31;
			4'd7:    month_days = 5'd31;
			4'd8:    month_days = 5'd30;
			4'd9:    month_days = 5'd31;
			4'd10:   month_days = 5'd30;
			default: month_days = 5'd31;
		endcase
	endfunction

	function automatic logic [8:0] year_days(input logic leap);
		year_days = leap ? 9'd366 : 9'd365;
	endfunction

endpackage

// ===== design/dad_alu.sv =====
module dad_alu (
	input  dad_pkg::acc_t     a,
	input  dad_pkg::acc_t     b,
	input  logic              sub,
	output dad_pkg::alu_res_t res
);

	logic [dad_pkg::AccW:0] sum;

	always_comb begin
		sum = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{dad_pkg::AccW{1'b0}}, sub};
		res.diff = sum[dad_pkg::AccW-1:0];
		// With subtraction the carry out means no borrow, so a is at least b.
		res.ge = sum[dad_pkg::AccW];
		res.gt = sum[dad_pkg::AccW] && (sum[dad_pkg::AccW-1:0] != '0);
	end

endmodule

// ===== design/dad_core.sv =====
module dad_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         start_day,
	input  logic [3:0]         start_month,
	input  logic [13:0]        start_year,
	input  logic [15:0]        days_to_add,
	output logic               res_valid,
	input  logic               res_ready,
	output dad_pkg::date_res_t result
);

	dad_pkg::state_t             state_q;
	dad_pkg::acc_t               acc_q;
	logic [dad_pkg::RemW-1:0]    rem_q;
	logic [dad_pkg::YearW-1:0]   year_q;
	logic [15:0]                 add_q;
	logic [3:0]                  mon_last_q;
	logic [3:0]                  cnt_q;
	dad_pkg::acc_t               alu_a;
	dad_pkg::acc_t               alu_b;
	logic                        alu_sub;
	dad_pkg::alu_res_t           alu_res;
	logic                        leap;
	logic [4:0]                  mdays;
	logic [4:0]                  day_fix;
	logic [3:0]                  mon_fix;

	assign leap  = dad_pkg::is_leap(rem_q);
	assign mdays = dad_pkg::month_days(cnt_q, leap);

	assign day_fix = (start_day == 5'd0) ? 5'd1 : start_day;
	assign mon_fix = (start_month == 4'd0) ? 4'd1 :
		((start_month > 4'd12) ? 4'd12 : start_month);

	// Operand selection for the shared adder.
	always_comb begin
		alu_a   = acc_q;
		alu_b   = dad_pkg::AccW'(mdays);
		alu_sub = 1'b1;
		case (state_q)
			dad_pkg::ST_MOD: begin
				alu_a = dad_pkg::AccW'(rem_q);
				alu_b = dad_pkg::QuadCentury << cnt_q[2:0];
			end
			dad_pkg::ST_DOY: begin
				alu_sub = 1'b0;
			end
			dad_pkg::ST_SUM: begin
				alu_b   = dad_pkg::AccW'(add_q);
				alu_sub = 1'b0;
			end
			dad_pkg::ST_YEAR: begin
				alu_b = dad_pkg::AccW'(dad_pkg::year_days(leap));
			end
			default: begin
			end
		endcase
	end

	dad_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.res (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dad_pkg::ST_IDLE;
		end else begin
			case (state_q)
				dad_pkg::ST_IDLE: begin
					if (in_valid) state_q <= dad_pkg::ST_MOD;
				end
				dad_pkg::ST_MOD: begin
					if (cnt_q == 4'd0) state_q <= dad_pkg::ST_DOY;
				end
				dad_pkg::ST_DOY: begin
					if (cnt_q == mon_last_q) state_q <= dad_pkg::ST_SUM;
				end
				dad_pkg::ST_SUM: begin
					state_q <= dad_pkg::ST_YEAR;
				end
				dad_pkg::ST_YEAR: begin
					if (!alu_res.gt) state_q <= dad_pkg::ST_MDAY;
				end
				dad_pkg::ST_MDAY: begin
					if (cnt_q == dad_pkg::LastMonth || !alu_res.gt) state_q <= dad_pkg::ST_DONE;
				end
				dad_pkg::ST_DONE: begin
					if (res_ready) state_q <= dad_pkg::ST_IDLE;
				end
				default: begin
					state_q <= dad_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dad_pkg::ST_IDLE: begin
				acc_q      <= dad_pkg::AccW'(day_fix);
				rem_q      <= start_year;
				year_q     <= dad_pkg::YearW'(start_year);
				add_q      <= days_to_add;
				mon_last_q <= mon_fix - 4'd1;
				cnt_q      <= {1'b0, dad_pkg::ModTopShift};
			end
			dad_pkg::ST_MOD: begin
				// Restoring reduction of the year modulo 400, one shifted multiple a cycle.
				if (alu_res.ge) rem_q <= alu_res.diff[dad_pkg::RemW-1:0];
				cnt_q <= (cnt_q == 4'd0) ? 4'd0 : cnt_q - 4'd1;
			end
			dad_pkg::ST_DOY: begin
				if (cnt_q != mon_last_q) begin
					acc_q <= alu_res.diff;
					cnt_q <= cnt_q + 4'd1;
				end else begin
					cnt_q <= 4'd0;
				end
			end
			dad_pkg::ST_SUM: begin
				acc_q <= alu_res.diff;
			end
			dad_pkg::ST_YEAR: begin
				if (alu_res.gt) begin
					acc_q  <= alu_res.diff;
					year_q <= year_q + dad_pkg::YearW'(1);
					rem_q  <= (rem_q == dad_pkg::RemLast) ? '0 : rem_q + dad_pkg::RemW'(1);
				end
			end
			dad_pkg::ST_MDAY: begin
				if (cnt_q != dad_pkg::LastMonth && alu_res.gt) begin
					acc_q <= alu_res.diff;
					cnt_q <= cnt_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready     = (state_q == dad_pkg::ST_IDLE);
	assign res_valid    = (state_q == dad_pkg::ST_DONE);
	assign result.day   = acc_q[4:0];
	assign result.month = cnt_q + 4'd1;
	assign result.year  = year_q[dad_pkg::YearW-1] ? dad_pkg::YearMax : year_q[13:0];

	// Once reduced, the year remainder must stay below 400.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dad_pkg::ST_DOY || state_q == dad_pkg::ST_YEAR
			|| state_q == dad_pkg::ST_MDAY) |-> (rem_q < dad_pkg::RemW'(400)))
		else $error("year remainder out of range");

	// The day offset entering month decomposition is a valid day of the year.
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dad_pkg::ST_MDAY) |-> (acc_q != '0 && acc_q <= dad_pkg::AccW'(366)))
		else $error("day offset out of range");

	// A finished result always has a nonzero day and a month index within range.
	a_result_day: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (result.day != 5'd0 && cnt_q <= dad_pkg::LastMonth))
		else $error("bad result date");

endmodule

// ===== design/date_add_days_top.sv =====
// The sequencer reduces the start year modulo 400, sums the days of the start months,
// adds days_to_add, then steps through the years crossed and the months of the end year.
// Throughput: one item at a time; the shared adder handles every step of the sequence.
// The next item can be taken in the cycle after a result moves to the output register.
// Reset (arst_n low, asynchronous) empties the sequencer and the output register.
module date_add_days_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // start_day[4:0], start_month[8:5], start_year[22:9],
	                               // days_to_add[38:23], zero[39]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // end_day[4:0], end_month[8:5], end_year[22:9], zero[23]
);

	dad_pkg::date_res_t core_res;
	dad_pkg::date_res_t out_q;
	logic               core_valid;
	logic               core_ready;
	logic               out_valid_q;

	assign core_ready = !out_valid_q || m_tready;

	dad_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.start_day   (s_tdata[4:0]),
		.start_month (s_tdata[8:5]),
		.start_year  (s_tdata[22:9]),
		.days_to_add (s_tdata[38:23]),
		.res_valid   (core_valid),
		.res_ready   (core_ready),
		.result      (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ready) begin
			out_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) out_q <= core_res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.year, out_q.month, out_q.day};

endmodule

// ===== sim/date_add_days_checker.sv =====
module date_add_days_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,   // start_day[4:0], start_month[8:5], start_year[22:9],
	                               // days_to_add[38:23], zero[39]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // end_day[4:0], end_month[8:5], end_year[22:9], zero[23]
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	dad_pkg::date_res_t dates_due[$];
	int unsigned        items_in    = 0;
	int unsigned        results_out = 0;

	initial fail_count = 0;

	assign outstanding = items_in - results_out;

	function automatic bit leap_year(input int unsigned yr);
		return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
	endfunction

	function automatic int unsigned year_length(input int unsigned yr);
		return leap_year(yr) ? 366 : 365;
	endfunction

	function automatic int unsigned month_length(input int unsigned idx, input int unsigned yr);
		int unsigned n;
		case (idx)
			1:          n = leap_year(yr) ? 29 : 28;
			3, 5, 8, 10: n = 30;
			default:    n = 31;
		endcase
		return n;
	endfunction

	function automatic dad_pkg::date_res_t shifted_date(input logic [39:0] item);
		int unsigned        day, mon, yr, add, doy, left, m;
		dad_pkg::date_res_t res;
		day = 32'(item[4:0]);
		mon = 32'(item[8:5]);
		yr  = 32'(item[22:9]);
		add = 32'(item[38:23]);
		if (day == 0)
			day = 1;
		if (mon == 0)
			mon = 1;
		else if (mon > 12)
			mon = 12;
		doy = day;
		for (m = 0; m + 1 < mon; m++)
			doy += month_length(m, yr);
		// A day past the end of its month simply runs on into the next months.
		left = year_length(yr) - doy;
		if (add <= left) begin
			doy += add;
		end else begin
			add -= left;
			yr++;
			while (add > year_length(yr)) begin
				add -= year_length(yr);
				yr++;
			end
			doy = add;
		end
		for (m = 0; m < 11; m++) begin
			if (doy <= month_length(m, yr))
				break;
			doy -= month_length(m, yr);
		end
		res.day   = 5'(doy);
		res.month = 4'(m + 1);
		res.year  = (yr > 32'(dad_pkg::YearMax)) ? dad_pkg::YearMax : 14'(yr);
		return res;
	endfunction

	task automatic compare_field(input string name, input int unsigned due,
		input int unsigned got);
		if (due != got) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, due, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		dad_pkg::date_res_t due;
		dad_pkg::date_res_t got;
		if (arst_n) begin
			// Results are retired before the new item is queued, so a result that
			// arrives with nothing pending is never matched against a fresh item.
			if (m_tvalid && m_tready) begin
				results_out <= results_out + 1;
				got = m_tdata[22:0];
				if (dates_due.size() == 0) begin
					$display("%0t: result with no item pending: expected none, got %0d-%0d-%0d",
						$time, got.year, got.month, got.day);
					fail_count++;
				end else begin
					due = dates_due.pop_front();
					compare_field("end_day", 32'(due.day), 32'(got.day));
					compare_field("end_month", 32'(due.month), 32'(got.month));
					compare_field("end_year", 32'(due.year), 32'(got.year));
				end
			end
			if (s_tvalid && s_tready) begin
				dates_due.push_back(shifted_date(s_tdata));
				items_in <= items_in + 1;
			end
		end
	end

endmodule

// ===== sim/date_add_days_top_test.sv =====
module date_add_days_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit  = 4000;
	localparam int HoldCycles  = 600;
	localparam int SettleTime  = 250;
	localparam int PhaseItems  = 285;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;

	int fail_count;
	int outstanding;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int quiet          = 0;

	always #5 clk = ~clk;

	date_add_days_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	date_add_days_checker date_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// The receiver counts its own long hold-off once the stimulus asks for one.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HoldCycles;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet == QuietLimit) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// Valid stays high between back-to-back items and is lowered only for a gap.
	task automatic send_date(input logic [4:0] day, input logic [3:0] mon,
		input logic [13:0] yr, input logic [15:0] add);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, add, yr, mon, day};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_random_date();
		logic [4:0]  day;
		logic [3:0]  mon;
		logic [13:0] yr;
		logic [15:0] add;
		day = ($urandom_range(19) == 0) ? 5'd0 : 5'($urandom_range(31, 1));
		mon = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(12, 1));
		case ($urandom_range(9))
			0:       yr = 14'($urandom);
			1:       yr = 14'(16383 - $urandom_range(200));
			2, 3:    yr = 14'(100 * $urandom_range(99) + $urandom_range(4));
			default: yr = 14'($urandom_range(9999));
		endcase
		case ($urandom_range(3))
			0:       add = 16'($urandom_range(31));
			1:       add = 16'($urandom_range(1500));
			default: add = 16'($urandom);
		endcase
		send_date(day, mon, yr, add);
	endtask

	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_date(5'd1, 4'd1, 14'd0, 16'd0);
		send_date(5'd29, 4'd2, 14'd0, 16'd0);
		send_date(5'd31, 4'd12, 14'd0, 16'd1);
		send_date(5'd0, 4'd0, 14'd2024, 16'd0);
		send_date(5'd31, 4'd15, 14'd16383, 16'd65535);
		send_date(5'd31, 4'd13, 14'd1999, 16'd1);
		send_date(5'd29, 4'd2, 14'd1900, 16'd0);
		send_date(5'd31, 4'd2, 14'd2000, 16'd0);
		send_date(5'd31, 4'd2, 14'd2001, 16'd0);
		send_date(5'd28, 4'd2, 14'd2100, 16'd1);
		send_date(5'd28, 4'd2, 14'd2400, 16'd1);
		send_date(5'd31, 4'd12, 14'd1999, 16'd0);
		send_date(5'd31, 4'd12, 14'd1999, 16'd366);
		send_date(5'd1, 4'd1, 14'd9999, 16'd65535);
		send_date(5'd15, 4'd6, 14'd16300, 16'd65535);
		send_date(5'd1, 4'd3, 14'd1600, 16'd36524);
		send_date(5'd31, 4'd1, 14'd2023, 16'd28);
		send_date(5'd30, 4'd4, 14'd2023, 16'd0);
		send_date(5'd1, 4'd1, 14'd2000, 16'd365);
		send_date(5'd1, 4'd1, 14'd2000, 16'd366);
		send_date(5'd31, 4'd12, 14'd16383, 16'd1);
		send_date(5'd0, 4'd12, 14'd100, 16'd65535);
		wait_for_results();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct  <= 86;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  <= 0;
					recv_stall_pct <= 86;
				end
				default: begin
					send_idle_pct  <= 13;
					recv_stall_pct <= 13;
				end
			endcase
			for (int n = 0; n < PhaseItems; n++) begin
				// While the receiver holds off, the sender keeps offering items.
				if (phase == 0 && n == 60)
					hold_req <= hold_req + 1;
				send_random_date();
			end
			wait_for_results();
		end

		repeat (SettleTime) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
design/dad_pkg.sv
design/dad_alu.sv
design/dad_core.sv
design/date_add_days_top.sv
sim/date_add_days_checker.sv
sim/date_add_days_top_test.sv
